@@ hdl/spq_pkg.sv @@
// Shared types and constants for the stable sorted priority queue.
package spq_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned CountW     = $clog2(Depth + 1);
  localparam int unsigned ValueW     = 32;
  localparam int unsigned PrioW      = 16;
  localparam int unsigned EntryCntW  = 5;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic   update;
    op_t    op;
    entry_t item;
  } cell_ctrl_t;

endpackage

@@ hdl/stable_sorted_priority_queue.sv @@
// Top level of the stable sorted priority queue built as a chain of cells.
//
// Usage:
//   Slave channel (s_*): one beat per request. s_tuser carries the operation
//   (enqueue or dequeue); s_tdata carries value and priority, ignored on dequeue.
//   Master channel (m_*): exactly one result beat per request, in request order.
//   The result reports the popped entry, the head after the request, the
//   stored count and a status (ok, dequeue on empty, enqueue on full).
//   Entries sit in a row of cells sorted by descending priority; an enqueue
//   makes every cell compare against the newcomer in parallel and the row opens
//   a gap at the insertion point; a dequeue shifts the whole row one cell
//   toward the head. Equal priorities leave in arrival order.
//   Latency: the result beat is valid in the cycle after the request is taken.
//   Throughput: one request per cycle while the receiver takes each result, set
//   by the cell update and the one-deep output register.
//   Reset empties the queue (count to zero) and drops any pending result.
//   When the receiver stalls, the result holds in the output register and the
//   slave side accepts nothing more until it is taken.
module stable_sorted_priority_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // [31:0] item_value, [47:32] item_priority
  input  logic [0:0]   s_tuser,   // [0] operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [31:0] popped_value, [47:32] popped_priority,
                                  // [79:48] head_value, [95:80] head_priority,
                                  // [100:96] entry_count, [103:101] zero
  output logic [2:0]   m_tuser    // [0] popped_valid, [2:1] status
);

  localparam int unsigned D = spq_pkg::Depth;

  logic [spq_pkg::CountW-1:0] count;
  logic [spq_pkg::CountW-1:0] count_next;
  logic                       accept;
  spq_pkg::cell_ctrl_t        ctrl;
  spq_pkg::status_t           status_next;
  logic                       is_full;
  logic                       is_empty;

  spq_pkg::entry_t cell_entry      [D];
  spq_pkg::entry_t cell_entry_next [D];
  logic            cell_keep       [D];

  // Output register.
  logic             out_valid;
  spq_pkg::entry_t  popped;
  logic             popped_valid;
  spq_pkg::entry_t  head;
  logic [spq_pkg::EntryCntW-1:0] entry_count;
  spq_pkg::status_t status;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (count == spq_pkg::CountW'(D));
  assign is_empty = (count == '0);

  // Decide status and whether the row moves this cycle.
  always_comb begin
    ctrl.op         = spq_pkg::op_t'(s_tuser[0]);
    ctrl.item.value = s_tdata[31:0];
    ctrl.item.prio  = s_tdata[47:32];
    ctrl.update     = 1'b0;
    status_next     = spq_pkg::ST_OK;
    count_next      = count;
    unique case (ctrl.op)
      spq_pkg::OP_ENQUEUE: begin
        if (is_full) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          ctrl.update = accept;
          count_next  = count + 1'b1;
        end
      end
      spq_pkg::OP_DEQUEUE: begin
        if (is_empty) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.update = accept;
          count_next  = count - 1'b1;
        end
      end
      default: status_next = spq_pkg::ST_OK;
    endcase
  end

  // Row of cells; the head sits in cell 0.
  for (genvar i = 0; i < D; i++) begin : g_cell
    spq_pkg::entry_t prev_e;
    spq_pkg::entry_t next_e;
    logic            prev_k;
    logic            occ;

    assign occ = (spq_pkg::CountW'(i) < count);

    if (i == 0) begin : g_head
      assign prev_e = ctrl.item;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = cell_entry[i-1];
      assign prev_k = cell_keep[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign next_e = cell_entry[i];
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .entry_next (cell_entry_next[i]),
      .keep       (cell_keep[i])
    );
  end

  // Count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: capture the popped head and the head after the update.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_valid <= 1'b0;
      popped       <= '0;
      if (ctrl.op == spq_pkg::OP_DEQUEUE && !is_empty) begin
        popped_valid <= 1'b1;
        popped       <= cell_entry[0];
      end
      if (count_next == '0) begin
        head <= '0;
      end else begin
        head <= cell_entry_next[0];
      end
      entry_count <= spq_pkg::EntryCntW'(count_next);
      status      <= status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, entry_count, head.prio, head.value,
                     popped.prio, popped.value};
  assign m_tuser  = {status, popped_valid};

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CountW'(D))
    else $error("stored count exceeds depth");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && popped_valid) |-> (status == spq_pkg::ST_OK))
    else $error("popped entry reported with error status");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.op == spq_pkg::OP_ENQUEUE && !is_full) |=> (count == $past(count) + 1'b1))
    else $error("enqueue did not grow the count");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_count == '0 && spq_pkg::Depth < 32) |-> (head == '0))
    else $error("head not zero on empty queue");

endmodule

@@ hdl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  spq_pkg::entry_t    prev_entry,
  input  logic               prev_keep,
  input  spq_pkg::entry_t    next_entry,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_next,
  output logic               keep
);

  // Stay put on enqueue when this entry ranks ahead of or level with the newcomer.
  assign keep = occupied && (entry.prio >= ctrl.item.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.update) begin
      unique case (ctrl.op)
        spq_pkg::OP_ENQUEUE: begin
          if (keep) begin
            entry_next = entry;
          end else if (prev_keep) begin
            entry_next = ctrl.item;
          end else begin
            entry_next = prev_entry;
          end
        end
        spq_pkg::OP_DEQUEUE: entry_next = next_entry;
        default:             entry_next = entry;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ sim/tb_stable_sorted_priority_queue.sv @@
// Testbench for the stable sorted priority queue: directed and random requests, scoreboard check.
import spq_pkg::*;

// Tracks the sorted store as the block should hold it and the result beats still owed.
class queue_tracker;
  typedef struct {
    logic [ValueW-1:0] popped_value;
    logic [PrioW-1:0]  popped_priority;
    logic              popped_valid;
    logic [ValueW-1:0] head_value;
    logic [PrioW-1:0]  head_priority;
    logic [4:0]        entry_count;
    status_t           status;
  } outcome_t;

  logic signed [ValueW-1:0] slot_value [Depth];
  logic signed [PrioW-1:0]  slot_prio [Depth];
  int unsigned              occupancy;
  outcome_t                 owed[$];
  int unsigned              mismatches;

  function new();
    occupancy  = 0;
    mismatches = 0;
  endfunction

  function int unsigned owed_count();
    return owed.size();
  endfunction

  // Apply one accepted request beat to the store and queue its outcome.
  function void note_request(op_t op, logic [47:0] data);
    outcome_t                 r;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
    int unsigned              pos;
    int unsigned              i;
    value             = data[31:0];
    prio              = data[47:32];
    r.popped_value    = '0;
    r.popped_priority = '0;
    r.popped_valid    = 1'b0;
    r.status          = ST_OK;
    if (op == OP_ENQUEUE) begin
      if (occupancy >= Depth) begin
        r.status = ST_FULL;
      end else begin
        // Land behind every entry of equal or higher priority.
        pos = 0;
        while (pos < occupancy && slot_prio[pos] >= prio) pos++;
        for (i = occupancy; i > pos; i--) begin
          slot_value[i] = slot_value[i-1];
          slot_prio[i]  = slot_prio[i-1];
        end
        slot_value[pos] = value;
        slot_prio[pos]  = prio;
        occupancy++;
      end
    end else if (occupancy == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped_value    = slot_value[0];
      r.popped_priority = slot_prio[0];
      r.popped_valid    = 1'b1;
      for (i = 0; i + 1 < occupancy; i++) begin
        slot_value[i] = slot_value[i+1];
        slot_prio[i]  = slot_prio[i+1];
      end
      occupancy--;
    end
    r.head_value    = (occupancy != 0) ? slot_value[0] : '0;
    r.head_priority = (occupancy != 0) ? slot_prio[0] : '0;
    r.entry_count   = 5'(occupancy);
    owed.push_back(r);
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one accepted result beat with the oldest owed outcome.
  function void check_result(logic [103:0] data, logic [2:0] user);
    outcome_t w;
    if (owed.size() == 0) begin
      $error("result beat with no request outstanding: tdata 0x%0h tuser 0x%0h", data, user);
      mismatches++;
      return;
    end
    w = owed.pop_front();
    check_field("popped_value", w.popped_value, data[31:0]);
    check_field("popped_priority", 32'(w.popped_priority), 32'(data[47:32]));
    check_field("popped_valid", 32'(w.popped_valid), 32'(user[0]));
    check_field("head_value", w.head_value, data[79:48]);
    check_field("head_priority", 32'(w.head_priority), 32'(data[95:80]));
    check_field("entry_count", 32'(w.entry_count), 32'(data[100:96]));
    check_field("status", 32'(w.status), 32'(user[2:1]));
  endfunction
endclass

module tb_stable_sorted_priority_queue;
  localparam int unsigned RandomRequests = 1650;
  localparam int unsigned CycleLimit     = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;    // [31:0] item_value, [47:32] item_priority
  logic [0:0]   s_tuser = '0;    // [0] operation
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;         // popped_value, popped_priority, head_value, head_priority,
                                 // entry_count, zero pad
  logic [2:0]   m_tuser;         // [0] popped_valid, [2:1] status

  queue_tracker tracker = new();
  int unsigned  cycles = 0;
  int unsigned  beats_taken = 0;
  int unsigned  hold_left = 0;
  bit           held_once = 1'b0;

  stable_sorted_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Note accepted requests before checking results taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.note_request(op_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
    end
  end

  // Receiver: random stalls, one long hold-off, and a stretch always ready
  // that lines up with the sender's stretch without idling.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) beats_taken++;
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (!held_once && beats_taken >= 400) begin
      held_once = 1'b1;
      hold_left = 150;
      m_tready <= 1'b0;
    end else if (beats_taken >= 1030 && beats_taken < 1320) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 38);
    end
  end

  // Offer one request beat and hold it until taken; idle beforehand at random.
  task automatic send_request(input op_t op, input logic [31:0] value,
                              input logic [15:0] prio, input bit may_idle);
    while (may_idle && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {prio, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_count() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned fill_pct;
    op_t         op;
    logic [15:0] prio;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: dequeue on empty, extremes, equal priorities, fill to full and
    // one dropped enqueue, then a few dequeues and a late top-priority arrival.
    send_request(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(OP_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF, 1'b1);
    send_request(OP_ENQUEUE, 32'h8000_0000, 16'h8000, 1'b1);
    send_request(OP_ENQUEUE, 32'h0000_0000, 16'h0000, 1'b1);
    send_request(OP_ENQUEUE, 32'h0000_0001, 16'h0000, 1'b1);
    send_request(OP_ENQUEUE, 32'h0000_0002, 16'h0000, 1'b1);
    send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(OP_ENQUEUE, 32'hAAAA_AAAA, 16'h0001, 1'b1);
    send_request(OP_ENQUEUE, 32'h5555_5555, 16'h7FFF, 1'b1);
    send_request(OP_ENQUEUE, 32'h1234_5678, 16'h8000, 1'b1);
    send_request(OP_ENQUEUE, 32'h0000_0010, 16'h0005, 1'b1);
    send_request(OP_ENQUEUE, 32'h0000_0011, 16'h0005, 1'b1);
    send_request(OP_ENQUEUE, 32'h0000_0012, 16'h0005, 1'b1);
    send_request(OP_ENQUEUE, 32'hDEAD_0000, 16'h0064, 1'b1);
    send_request(OP_ENQUEUE, 32'h0000_BEEF, 16'hFF9C, 1'b1);
    send_request(OP_ENQUEUE, 32'h0F0F_0F0F, 16'h5555, 1'b1);
    send_request(OP_ENQUEUE, 32'hF0F0_F0F0, 16'hAAAA, 1'b1);
    send_request(OP_ENQUEUE, 32'hCAFE_CAFE, 16'h7FFF, 1'b1);
    send_request(OP_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b1);
    send_request(OP_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b1);
    send_request(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(OP_ENQUEUE, 32'h7777_7777, 16'h7FFF, 1'b1);
    send_request(OP_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b1);

    // Random: pick a fill-heavy or drain-heavy bias per burst so the queue swings
    // between empty and full; priorities crowd a narrow band to force ties.
    fill_pct = 50;
    for (n = 0; n < RandomRequests; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0:       fill_pct = 10;
          1:       fill_pct = 40;
          2:       fill_pct = 65;
          default: fill_pct = 90;
        endcase
      end
      op = ($urandom_range(99) < fill_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: prio = 16'($signed($urandom_range(6)) - 3);
        5:             prio = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
        default:       prio = 16'($urandom);
      endcase
      send_request(op, $urandom, prio, !(n >= 1000 && n < 1300));
      if (n == 850) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed_count() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
